// ===== rtl/text_console_cursor_scroll_defines.svh =====
// Assertion macros shared by the console modules.
// Every user clocks on i_clk and resets on i_rst_n.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define TCCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tccs_pkg.sv =====
package tccs_pkg;

    localparam int COLUMNS = 40;
    localparam int ROWS    = 13;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int COL_W   = 6;
    localparam int LINE_W  = 4;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 3;
    localparam int RIDX_W  = 10;

    localparam int CFG_IDX_W  = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_USED_W  = COL_W + LINE_W + CELL_W;

    localparam int TAB_STOP = 8;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0220;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_CURSOR = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_COLOR = 1'd0,
        CFG_BLANK_CELL = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                cmd;
        logic [CHAR_W-1:0]   char_code;
        logic [COL_W-1:0]    new_column;
        logic [LINE_W-1:0]   new_line;
        logic [RIDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [LINE_W-1:0] cursor_line;
        logic [CELL_W-1:0] cell_word;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

// ===== rtl/tccs_ram.sv =====
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 520
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tccs_ctrl.sv =====
module tccs_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  tccs_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [tccs_pkg::CELL_W-1:0]         i_cfg_wdata,
    input  logic                                i_item_valid,
    output logic                                o_item_ready,
    input  tccs_pkg::t_item                     i_item,
    output tccs_pkg::t_ram_req                  o_ram,
    input  logic [tccs_pkg::CELL_W-1:0]         i_rd_data,
    output logic                                o_res_load,
    input  logic                                i_res_ready,
    output tccs_pkg::t_result                   o_res
);

    `include "text_console_cursor_scroll_defines.svh"

    localparam int AW = tccs_pkg::ADDR_W;
    localparam logic [AW-1:0] COLS_A = AW'(tccs_pkg::COLUMNS);
    localparam logic [AW-1:0] LAST_A = AW'(tccs_pkg::CELLS - 1);
    localparam logic [AW-1:0] MOVE_A = AW'(tccs_pkg::CELLS - tccs_pkg::COLUMNS);
    localparam logic [tccs_pkg::COL_W-1:0]  LAST_COL  = tccs_pkg::COL_W'(tccs_pkg::COLUMNS - 1);
    localparam logic [tccs_pkg::COL_W-1:0]  NUM_COLS  = tccs_pkg::COL_W'(tccs_pkg::COLUMNS);
    localparam logic [tccs_pkg::COL_W-1:0]  TAB_MASK  = tccs_pkg::COL_W'(tccs_pkg::TAB_STOP - 1);
    localparam logic [tccs_pkg::LINE_W-1:0] LAST_LINE = tccs_pkg::LINE_W'(tccs_pkg::ROWS - 1);
    localparam logic [tccs_pkg::LINE_W-1:0] NUM_LINES = tccs_pkg::LINE_W'(tccs_pkg::ROWS);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_GLYPH  = 8'b0000_0100,
        S_SCROLL = 8'b0000_1000,
        S_FILL   = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_RDCAP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    function automatic logic [tccs_pkg::CELL_W-1:0] glyph_cell(
        input logic [tccs_pkg::COLOR_W-1:0] color,
        input logic [tccs_pkg::CHAR_W-1:0]  c
    );
        // colour and low char bit above the 0x200 marker, char with bit 0 cleared below
        glyph_cell = {2'b00, color, c[0], 2'b10, c[7:1], 1'b0};
    endfunction

    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_cnt, n_cnt;
    logic [tccs_pkg::COL_W-1:0]      r_col, n_col;
    logic [tccs_pkg::LINE_W-1:0]     r_line, n_line;
    logic [tccs_pkg::COLOR_W-1:0]    r_color;
    logic [tccs_pkg::CELL_W-1:0]     r_blank;
    logic [tccs_pkg::CHAR_W-1:0]     r_char, n_char;
    logic                            r_tab, n_tab;
    logic [tccs_pkg::RIDX_W-1:0]     r_ridx, n_ridx;
    logic [tccs_pkg::CELL_W-1:0]     r_cell, n_cell;

    logic [AW-1:0]                   cur_addr;
    logic [tccs_pkg::COL_W-1:0]      col_inc;
    logic                            accept;

    assign cur_addr     = AW'(r_line) * COLS_A + AW'(r_col);
    assign col_inc      = r_col + 1'b1;
    assign o_item_ready = (r_state == S_IDLE);
    assign accept       = i_item_valid && o_item_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_col   = r_col;
        n_line  = r_line;
        n_char  = r_char;
        n_tab   = r_tab;
        n_ridx  = r_ridx;
        n_cell  = r_cell;
        o_ram   = '0;
        o_res_load = 1'b0;

        case (r_state)
            S_INIT: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_cnt;
                o_ram.wr_data = tccs_pkg::RESET_CELL;
                if (r_cnt == LAST_A) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    n_cell = '0;
                    case (i_item.cmd)
                        tccs_pkg::CMD_PUT: begin
                            case (i_item.char_code)
                                tccs_pkg::CHAR_BS: begin
                                    if (r_col != '0) begin
                                        n_col = r_col - 1'b1;
                                    end
                                    n_state = S_DONE;
                                end
                                tccs_pkg::CHAR_TAB: begin
                                    n_char  = tccs_pkg::CHAR_SPACE;
                                    n_tab   = 1'b1;
                                    n_state = S_GLYPH;
                                end
                                tccs_pkg::CHAR_LF: begin
                                    n_col = '0;
                                    if (r_line == LAST_LINE) begin
                                        n_cnt   = '0;
                                        n_state = S_SCROLL;
                                    end else begin
                                        n_line  = r_line + 1'b1;
                                        n_state = S_DONE;
                                    end
                                end
                                tccs_pkg::CHAR_CR: begin
                                    n_col   = '0;
                                    n_state = S_DONE;
                                end
                                default: begin
                                    n_char  = i_item.char_code;
                                    n_tab   = 1'b0;
                                    n_state = S_GLYPH;
                                end
                            endcase
                        end
                        tccs_pkg::CMD_CURSOR: begin
                            n_col   = (i_item.new_column < NUM_COLS) ? i_item.new_column
                                                                      : LAST_COL;
                            n_line  = (i_item.new_line < NUM_LINES) ? i_item.new_line
                                                                     : LAST_LINE;
                            n_state = S_DONE;
                        end
                        tccs_pkg::CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        tccs_pkg::CMD_READ: begin
                            n_ridx = i_item.read_index;
                            if (i_item.read_index < tccs_pkg::RIDX_W'(tccs_pkg::CELLS)) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_GLYPH: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = cur_addr;
                o_ram.wr_data = glyph_cell(r_color, r_char);
                if (col_inc >= NUM_COLS) begin
                    // wrap ends a tab too, as the column is back at zero
                    n_col = '0;
                    if (r_line == LAST_LINE) begin
                        n_cnt   = '0;
                        n_state = S_SCROLL;
                    end else begin
                        n_line  = r_line + 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_col = col_inc;
                    if (!(r_tab && ((col_inc & TAB_MASK) != '0))) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the word read last cycle one row up
                o_ram.rd_en   = (r_cnt < MOVE_A);
                o_ram.rd_addr = r_cnt + COLS_A;
                o_ram.wr_en   = (r_cnt != '0);
                o_ram.wr_addr = r_cnt - 1'b1;
                o_ram.wr_data = i_rd_data;
                if (r_cnt == MOVE_A) begin
                    n_state = S_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FILL: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_cnt;
                o_ram.wr_data = r_blank;
                if (r_cnt == LAST_A) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_READ: begin
                o_ram.rd_en   = 1'b1;
                o_ram.rd_addr = AW'(r_ridx);
                n_state       = S_RDCAP;
            end
            S_RDCAP: begin
                n_cell  = i_rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_col   <= '0;
            r_line  <= '0;
            r_color <= '0;
            r_blank <= tccs_pkg::RESET_CELL;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_line  <= n_line;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tccs_pkg::CFG_TEXT_COLOR: r_color <= i_cfg_wdata[tccs_pkg::COLOR_W-1:0];
                    tccs_pkg::CFG_BLANK_CELL: r_blank <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_tab  <= n_tab;
        r_ridx <= n_ridx;
        r_cell <= n_cell;
    end

    assign o_res.cursor_column = r_col;
    assign o_res.cursor_line   = r_line;
    assign o_res.cell_word     = r_cell;

    `TCCS_ASSERT_NOW(a_no_rw_collision, o_ram.wr_en && o_ram.rd_en,
        o_ram.wr_addr != o_ram.rd_addr, "read and write hit the same cell")
    `TCCS_ASSERT_NOW(a_cursor_bounds, 1'b1,
        (r_col < NUM_COLS) && (r_line < NUM_LINES), "cursor left the screen")
    `TCCS_ASSERT_NOW(a_scroll_cursor, r_state == S_SCROLL,
        (r_line == LAST_LINE) && (r_col == '0), "scroll with cursor off the last row start")
    `TCCS_ASSERT_NEXT(a_clear_starts, accept && (i_item.cmd == tccs_pkg::CMD_CLEAR),
        (r_state == S_FILL) && (r_cnt == '0), "clear did not start at cell zero")

endmodule

// ===== rtl/tccs_out.sv =====
module tccs_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tccs_pkg::t_result   i_res,
    output logic                o_load_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output tccs_pkg::t_result   o_m_res
);

    `include "text_console_cursor_scroll_defines.svh"

    logic              r_valid;
    tccs_pkg::t_result r_res;

    // slot is free when empty or being drained this cycle
    assign o_load_ready = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_res   = r_res;

    `TCCS_ASSERT_NOW(a_no_overwrite, i_load && r_valid, i_m_ready,
        "result overwritten before transfer")

endmodule

// ===== rtl/text_console_cursor_scroll.sv =====
// Channel   Dir  Signals                        Contents
// --------  ---  -----------------------------  --------------------------------------
// command   in   s_axis_tvalid/tready/tdata/    one console command per transfer
//                tuser
// result    out  m_axis_tvalid/tready/tdata     cursor and read cell after a command
// config    in   i_cfg_we/i_cfg_index/          text_color (0), blank_cell (1)
//                i_cfg_wdata
//
// Put character writes one cell, read cell reads one, and tab writes spaces up to the next
// tab stop (up to 8); backspace, return, set cursor and other short commands touch no cell.
// Newline or wrap on the last row: a row-up copy through the single read port, then a
// bottom row fill; clear fills all 520 cells. Config writes go in at any time.
// Reset: synchronous, active low; a clearing pass writes the reset blank into
// every cell, and no command is taken until it ends. Stalls: the result register holds
// one result, so the next command is taken while it waits; a second waits in the sequencer.
module text_console_cursor_scroll (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [tccs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tccs_pkg::CELL_W-1:0]           i_cfg_wdata,
    // command stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] char_code, [13:8] new_column, [17:14] new_line, [27:18] read_index, rest zero
    input  logic [tccs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] cmd
    input  logic [tccs_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [5:0] cursor_column_out, [9:6] cursor_line_out, [25:10] cell_word, rest zero
    output logic [tccs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    tccs_pkg::t_item     item;
    tccs_pkg::t_ram_req  ram_req;
    tccs_pkg::t_result   res;
    tccs_pkg::t_result   m_res;
    logic [tccs_pkg::CELL_W-1:0] rd_data;
    logic                res_load;
    logic                res_ready;

    // unpack the command transfer
    assign item.cmd        = tccs_pkg::t_cmd'(s_axis_tuser);
    assign item.char_code  = s_axis_tdata[7:0];
    assign item.new_column = s_axis_tdata[13:8];
    assign item.new_line   = s_axis_tdata[17:14];
    assign item.read_index = s_axis_tdata[27:18];

    tccs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (tccs_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .o_ram        (ram_req),
        .i_rd_data    (rd_data),
        .o_res_load   (res_load),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // screen memory, one cell per word, row by row
    tccs_ram #(
        .WIDTH (tccs_pkg::CELL_W),
        .DEPTH (tccs_pkg::CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    tccs_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_load),
        .i_res        (res),
        .o_load_ready (res_ready),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_res      (m_res)
    );

    // pack the result transfer, padding above the cell word
    assign m_axis_tdata = {{(tccs_pkg::OUT_TDATA_W - tccs_pkg::OUT_USED_W){1'b0}},
                           m_res.cell_word, m_res.cursor_line, m_res.cursor_column};

endmodule
